@@ sv/cffd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffd_pkg
// Shared types and field widths of the capped first-fit job dispatcher.
// ----------------------------------------------------------------------------
package cffd_pkg;

    localparam int USER_INDEX_W = 6;
    localparam int HOST_INDEX_W = 8;
    localparam int FIELD_W      = 16;
    localparam int CFG_INDEX_W  = 2;

    typedef enum logic [1:0] {
        OP_LOAD_USER   = 2'd0,
        OP_LOAD_HOST   = 2'd1,
        OP_START_ROUND = 2'd2,
        OP_CANDIDATE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        OUT_PLACED      = 3'd0,
        OUT_NO_FIT      = 3'd1,
        OUT_USER_CAPPED = 3'd2,
        OUT_PASS_MISS   = 3'd3,
        OUT_ROUND_LIMIT = 3'd4
    } outcome_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_DISPATCH_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_USER_JOB_LIMIT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOST_JOB_LIMIT = 2'd2;

endpackage

@@ sv/cffd_count_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffd_count_mem
// Counter memory with registered read, write-to-read bypass and per-entry
// valid bits; an entry that is not valid reads as zero.
// ----------------------------------------------------------------------------
module cffd_count_mem #(
    parameter  int DEPTH = 64,
    parameter  int WIDTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             clr
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] raw_reg;
    logic [WIDTH-1:0] byp_reg;
    logic             hit_reg;
    logic             live_reg;
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            raw_reg <= mem[rd_addr];
            byp_reg <= wr_data;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (clr)
        begin
            valid_next = '0;
        end
        else if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
            live_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                // a write in the same cycle wins over the stored word
                hit_reg  <= wr_en && (wr_addr == rd_addr);
                live_reg <= valid_reg[rd_addr] && !clr;
            end
        end
    end

    assign rd_data = hit_reg ? byp_reg : (live_reg ? raw_reg : '0);

endmodule

@@ sv/capped_first_fit_job_dispatch.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capped_first_fit_job_dispatch
// First-fit job placement on hosts with per-round, per-user and per-host caps.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes load, round-start and candidate
//   items; an item is taken at an edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall) gives one decision per placed or
//   rejected job. Config writes (cfg_valid / cfg_ready, cfg_index, cfg_data)
//   are always ready and belong in idle periods.
//   Flow: an item is captured with its counter reads at the accept edge,
//   then decided once the output register is free; a decision loads the
//   output register, which drives out_valid.
//   Throughput: one item per cycle while the output is not stalled; the four
//   counter memories do one read and one write per cycle, with a bypass for
//   back-to-back items that touch the same user or host.
//   Stall: while a result waits under out_stall, one more item is taken and
//   held; then in_stall rises until the output register is free.
//   Reset: all counters, limits, the round total and the settled flag read as
//   zero right after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module capped_first_fit_job_dispatch
    import cffd_pkg::*;
#(
    parameter int USER_COUNT = 64,
    parameter int HOST_COUNT = 256,
    parameter int COUNT_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [FIELD_W-1:0]      cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              opcode,
    input  logic [USER_INDEX_W-1:0] user_index,
    input  logic [HOST_INDEX_W-1:0] host_index,
    input  logic [FIELD_W-1:0]      load_value,
    input  logic [FIELD_W-1:0]      offered_slots,
    input  logic [FIELD_W-1:0]      needed_slots,
    input  logic [FIELD_W-1:0]      job_number,
    input  logic                    has_pending_reason,
    input  logic                    reschedule_pass,
    input  logic                    first_host,
    input  logic                    last_host,
    input  logic [FIELD_W-1:0]      queue_rank,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2:0]              outcome,
    output logic [FIELD_W-1:0]      result_job,
    output logic [HOST_INDEX_W-1:0] result_host,
    output logic [FIELD_W-1:0]      result_rank
);

    localparam int UAW = $clog2(USER_COUNT);
    localparam int HAW = $clog2(HOST_COUNT);
    localparam int CB  = COUNT_BITS;
    localparam int CW  = (CB + 1 > FIELD_W + 1) ? CB + 1 : FIELD_W + 1;

    function automatic int wrap_mod(input int v, input int n);
        int r;
        r = v;
        while (r >= n)
        begin
            r = r - n;
        end
        return r;
    endfunction

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
        return (v == {CB{1'b1}}) ? v : v + 1'b1;
    endfunction

    // index wrap tables, built at elaboration
    logic [UAW-1:0] user_wrap [2**USER_INDEX_W];
    logic [HAW-1:0] host_wrap [2**HOST_INDEX_W];

    for (genvar g = 0; g < 2**USER_INDEX_W; g++)
    begin : g_user_wrap
        assign user_wrap[g] = UAW'(wrap_mod(g, USER_COUNT));
    end
    for (genvar g = 0; g < 2**HOST_INDEX_W; g++)
    begin : g_host_wrap
        assign host_wrap[g] = HAW'(wrap_mod(g, HOST_COUNT));
    end

    // configuration
    logic [FIELD_W-1:0] dispatch_limit_reg;
    logic [FIELD_W-1:0] user_job_limit_reg;
    logic [FIELD_W-1:0] host_job_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dispatch_limit_reg <= '0;
            user_job_limit_reg <= '0;
            host_job_limit_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DISPATCH_LIMIT: dispatch_limit_reg <= cfg_data;
                CFG_USER_JOB_LIMIT: user_job_limit_reg <= cfg_data;
                CFG_HOST_JOB_LIMIT: host_job_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic exec;
    logic accept;

    assign exec     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !exec;
    assign accept   = in_valid && !in_stall;

    // decision stage payload
    opcode_t            s1_op_reg;
    logic [UAW-1:0]     s1_uidx_reg;
    logic [HAW-1:0]     s1_hidx_reg;
    logic [FIELD_W-1:0] s1_load_reg;
    logic [FIELD_W-1:0] s1_offered_reg;
    logic [FIELD_W-1:0] s1_needed_reg;
    logic [FIELD_W-1:0] s1_job_reg;
    logic               s1_reason_reg;
    logic               s1_pass_reg;
    logic               s1_first_reg;
    logic               s1_last_reg;
    logic [FIELD_W-1:0] s1_rank_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg      <= opcode_t'(opcode);
            s1_uidx_reg    <= user_wrap[user_index];
            s1_hidx_reg    <= host_wrap[host_index];
            s1_load_reg    <= load_value;
            s1_offered_reg <= offered_slots;
            s1_needed_reg  <= needed_slots;
            s1_job_reg     <= job_number;
            s1_reason_reg  <= has_pending_reason;
            s1_pass_reg    <= reschedule_pass;
            s1_first_reg   <= first_host;
            s1_last_reg    <= last_host;
            s1_rank_reg    <= queue_rank;
        end
    end

    // counter memories
    logic [CB-1:0] urun_rd;
    logic [CB-1:0] udisp_rd;
    logic [CB-1:0] hused_rd;
    logic [CB-1:0] hdisp_rd;
    logic          urun_we;
    logic          hused_we;
    logic          disp_we;
    logic          round_clr;
    logic [CB-1:0] load_cnt;
    logic [CB-1:0] udisp_inc;
    logic [CB-1:0] hdisp_inc;

    assign load_cnt  = CB'(s1_load_reg);
    assign udisp_inc = sat_inc(udisp_rd);
    assign hdisp_inc = sat_inc(hdisp_rd);

    cffd_count_mem #(.DEPTH(USER_COUNT), .WIDTH(CB)) u_user_run (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (user_wrap[user_index]),
        .rd_data (urun_rd),
        .wr_en   (urun_we),
        .wr_addr (s1_uidx_reg),
        .wr_data (load_cnt),
        .clr     (1'b0)
    );

    cffd_count_mem #(.DEPTH(USER_COUNT), .WIDTH(CB)) u_user_disp (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (user_wrap[user_index]),
        .rd_data (udisp_rd),
        .wr_en   (disp_we),
        .wr_addr (s1_uidx_reg),
        .wr_data (udisp_inc),
        .clr     (round_clr)
    );

    cffd_count_mem #(.DEPTH(HOST_COUNT), .WIDTH(CB)) u_host_used (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (host_wrap[host_index]),
        .rd_data (hused_rd),
        .wr_en   (hused_we),
        .wr_addr (s1_hidx_reg),
        .wr_data (load_cnt),
        .clr     (1'b0)
    );

    cffd_count_mem #(.DEPTH(HOST_COUNT), .WIDTH(CB)) u_host_disp (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (host_wrap[host_index]),
        .rd_data (hdisp_rd),
        .wr_en   (disp_we),
        .wr_addr (s1_hidx_reg),
        .wr_data (hdisp_inc),
        .clr     (round_clr)
    );

    // decision
    logic [CB-1:0] round_total_reg;
    logic [CB-1:0] round_total_next;
    logic          settled_reg;
    logic          settled_next;
    logic          settled_eff;
    logic          round_hit;
    logic          user_hit;
    logic          pass_miss;
    logic          host_capped;
    logic          host_fits;
    logic [CW-1:0] user_sum;
    logic [CW-1:0] host_sum;
    logic [CW-1:0] need_sum;
    logic          emit;
    outcome_t      code;
    logic          placed;

    assign settled_eff = s1_first_reg ? 1'b0 : settled_reg;
    assign user_sum    = CW'(urun_rd) + CW'(udisp_rd);
    assign host_sum    = CW'(hused_rd) + CW'(hdisp_rd);
    assign need_sum    = CW'(s1_needed_reg) + CW'(hdisp_rd);
    assign round_hit   = (dispatch_limit_reg != '0)
                      && (CW'(round_total_reg) >= CW'(dispatch_limit_reg));
    assign user_hit    = (user_job_limit_reg != '0) && (user_sum >= CW'(user_job_limit_reg));
    assign pass_miss   = s1_reason_reg != s1_pass_reg;
    assign host_capped = (host_job_limit_reg != '0) && (host_sum >= CW'(host_job_limit_reg));
    assign host_fits   = CW'(s1_offered_reg) >= need_sum;

    always_comb
    begin
        urun_we          = 1'b0;
        hused_we         = 1'b0;
        disp_we          = 1'b0;
        round_clr        = 1'b0;
        emit             = 1'b0;
        placed           = 1'b0;
        code             = OUT_NO_FIT;
        round_total_next = round_total_reg;
        settled_next     = settled_reg;
        if (exec)
        begin
            unique case (s1_op_reg)
                OP_LOAD_USER:
                begin
                    urun_we = 1'b1;
                end
                OP_LOAD_HOST:
                begin
                    hused_we = 1'b1;
                end
                OP_START_ROUND:
                begin
                    round_clr        = 1'b1;
                    round_total_next = '0;
                    settled_next     = 1'b0;
                end
                OP_CANDIDATE:
                begin
                    settled_next = settled_eff;
                    if (!settled_eff)
                    begin
                        // job checks first, then this host
                        if (round_hit)
                        begin
                            emit = 1'b1;
                            code = OUT_ROUND_LIMIT;
                        end
                        else if (user_hit)
                        begin
                            emit = 1'b1;
                            code = OUT_USER_CAPPED;
                        end
                        else if (pass_miss)
                        begin
                            emit = 1'b1;
                            code = OUT_PASS_MISS;
                        end
                        else if (!host_capped && host_fits)
                        begin
                            emit             = 1'b1;
                            placed           = 1'b1;
                            code             = OUT_PLACED;
                            disp_we          = 1'b1;
                            round_total_next = sat_inc(round_total_reg);
                        end
                        else if (s1_last_reg)
                        begin
                            emit = 1'b1;
                            code = OUT_NO_FIT;
                        end
                        if (emit)
                        begin
                            settled_next = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign s1_valid_next  = accept ? 1'b1 : (exec ? 1'b0 : s1_valid_reg);
    assign out_valid_next = emit ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            round_total_reg <= '0;
            settled_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            round_total_reg <= round_total_next;
            settled_reg     <= settled_next;
        end
    end

    // result register
    logic [2:0]              outcome_reg;
    logic [FIELD_W-1:0]      result_job_reg;
    logic [HOST_INDEX_W-1:0] result_host_reg;
    logic [FIELD_W-1:0]      result_rank_reg;

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            outcome_reg     <= code;
            result_job_reg  <= s1_job_reg;
            result_host_reg <= placed ? HOST_INDEX_W'(s1_hidx_reg) : '0;
            result_rank_reg <= placed ? s1_rank_reg : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign outcome     = outcome_reg;
    assign result_job  = result_job_reg;
    assign result_host = result_host_reg;
    assign result_rank = result_rank_reg;

endmodule

@@ sv/cffd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffd_port_checks
// Port-level checks of the capped first-fit job dispatcher.
// ----------------------------------------------------------------------------
module cffd_port_checks
    import cffd_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [2:0]              outcome,
    input logic [FIELD_W-1:0]      result_job,
    input logic [HOST_INDEX_W-1:0] result_host,
    input logic [FIELD_W-1:0]      result_rank
);

    // a held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(outcome) && $stable(result_job)
                                      && $stable(result_host) && $stable(result_rank)))
        else $error("stalled result changed");

    // input backs up only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output free");

    // rejections carry no host or rank
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && outcome != OUT_PLACED) |-> (result_host == '0 && result_rank == '0))
        else $error("rejection with host data");

    // only defined outcome codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (outcome <= OUT_ROUND_LIMIT))
        else $error("undefined outcome code");

endmodule

bind capped_first_fit_job_dispatch cffd_port_checks u_cffd_port_checks (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .outcome     (outcome),
    .result_job  (result_job),
    .result_host (result_host),
    .result_rank (result_rank)
);

@@ bench/cffd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffd_checker
// Watches the config, item and decision channels of the first-fit dispatcher,
// keeps its own copy of the counters and limits, and compares every decision
// taken from the block, field by field, with the oldest one predicted.
// ----------------------------------------------------------------------------
module cffd_checker
    import cffd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [FIELD_W-1:0]      cfg_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [1:0]              opcode,
    input  logic [USER_INDEX_W-1:0] user_index,
    input  logic [HOST_INDEX_W-1:0] host_index,
    input  logic [FIELD_W-1:0]      load_value,
    input  logic [FIELD_W-1:0]      offered_slots,
    input  logic [FIELD_W-1:0]      needed_slots,
    input  logic [FIELD_W-1:0]      job_number,
    input  logic                    has_pending_reason,
    input  logic                    reschedule_pass,
    input  logic                    first_host,
    input  logic                    last_host,
    input  logic [FIELD_W-1:0]      queue_rank,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [2:0]              outcome,
    input  logic [FIELD_W-1:0]      result_job,
    input  logic [HOST_INDEX_W-1:0] result_host,
    input  logic [FIELD_W-1:0]      result_rank,
    output int                      fail_count,
    output int                      pending
);

    localparam int USERS = 1 << USER_INDEX_W;
    localparam int HOSTS = 1 << HOST_INDEX_W;

    typedef struct {
        outcome_t                verdict;
        logic [FIELD_W-1:0]      job;
        logic [HOST_INDEX_W-1:0] host;
        logic [FIELD_W-1:0]      rank;
    } decision_t;

    logic [FIELD_W-1:0] user_running [USERS];
    logic [FIELD_W-1:0] host_used    [HOSTS];
    logic [FIELD_W-1:0] user_placed  [USERS];
    logic [FIELD_W-1:0] host_placed  [HOSTS];
    logic [FIELD_W-1:0] placed_total;
    logic               job_done;
    logic [FIELD_W-1:0] round_cap;
    logic [FIELD_W-1:0] user_cap;
    logic [FIELD_W-1:0] host_cap;
    decision_t          decisions_due[$];
    int                 failures = 0;

    function automatic logic [FIELD_W-1:0] bump(input logic [FIELD_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic clear_round();
        for (int u = 0; u < USERS; u++)
            user_placed[u] = '0;
        for (int h = 0; h < HOSTS; h++)
            host_placed[h] = '0;
        placed_total = '0;
        job_done     = 1'b0;
    endtask

    task automatic clear_all();
        for (int u = 0; u < USERS; u++)
            user_running[u] = '0;
        for (int h = 0; h < HOSTS; h++)
            host_used[h] = '0;
        round_cap = '0;
        user_cap  = '0;
        host_cap  = '0;
        clear_round();
    endtask

    // one item in, at most one decision predicted
    task automatic judge_item();
        decision_t        d;
        logic             decided;
        logic [FIELD_W:0] user_load;
        logic [FIELD_W:0] host_load;
        logic [FIELD_W:0] demand;
        decided = 1'b0;
        d.verdict = OUT_PLACED;
        d.job  = job_number;
        d.host = '0;
        d.rank = '0;
        case (opcode_t'(opcode))
            OP_LOAD_USER:   user_running[user_index] = load_value;
            OP_LOAD_HOST:   host_used[host_index] = load_value;
            OP_START_ROUND: clear_round();
            default:
            begin
                if (first_host)
                    job_done = 1'b0;
                if (!job_done)
                begin
                    user_load = {1'b0, user_running[user_index]} + user_placed[user_index];
                    host_load = {1'b0, host_used[host_index]} + host_placed[host_index];
                    demand    = {1'b0, needed_slots} + host_placed[host_index];
                    decided   = 1'b1;
                    if (round_cap != 0 && placed_total >= round_cap)
                        d.verdict = OUT_ROUND_LIMIT;
                    else if (user_cap != 0 && user_load >= user_cap)
                        d.verdict = OUT_USER_CAPPED;
                    else if (has_pending_reason != reschedule_pass)
                        d.verdict = OUT_PASS_MISS;
                    else if (!(host_cap != 0 && host_load >= host_cap) &&
                             offered_slots >= demand)
                    begin
                        d.verdict = OUT_PLACED;
                        d.host    = host_index;
                        d.rank    = queue_rank;
                        host_placed[host_index] = bump(host_placed[host_index]);
                        user_placed[user_index] = bump(user_placed[user_index]);
                        placed_total = bump(placed_total);
                    end
                    else if (last_host)
                        d.verdict = OUT_NO_FIT;
                    else
                        decided = 1'b0;
                    if (decided)
                    begin
                        job_done = 1'b1;
                        decisions_due.push_back(d);
                    end
                end
            end
        endcase
    endtask

    task automatic check_field(input string what, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h got %h", $time, what, want, got);
            failures++;
        end
    endtask

    task automatic check_result();
        decision_t want;
        if (decisions_due.size() == 0)
        begin
            $display("%0t: decision expected none got job %h outcome %0d",
                     $time, result_job, outcome);
            failures++;
        end
        else
        begin
            want = decisions_due.pop_front();
            check_field("outcome", FIELD_W'(want.verdict), FIELD_W'(outcome));
            check_field("result_job", want.job, result_job);
            check_field("result_host", FIELD_W'(want.host), FIELD_W'(result_host));
            check_field("result_rank", want.rank, result_rank);
        end
    endtask

    initial
        clear_all();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_all();
            decisions_due.delete();
            pending <= 0;
        end
        else
        begin
            // results taken this edge come from items accepted at an earlier edge
            if (out_valid && !out_stall)
                check_result();
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DISPATCH_LIMIT: round_cap = cfg_data;
                    CFG_USER_JOB_LIMIT: user_cap  = cfg_data;
                    CFG_HOST_JOB_LIMIT: host_cap  = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                judge_item();
            pending    <= decisions_due.size();
            fail_count <= failures;
        end
    end

endmodule

@@ bench/capped_first_fit_job_dispatch_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capped_first_fit_job_dispatch_test
// Drives load, round-start and candidate items into the dispatcher under
// several limit settings, with random gaps and output stalls; the checker
// beside the block predicts each decision and counts mismatches.
// ----------------------------------------------------------------------------
module capped_first_fit_job_dispatch_test;
    import cffd_pkg::*;

    typedef struct packed {
        opcode_t                 op;
        logic [USER_INDEX_W-1:0] user;
        logic [HOST_INDEX_W-1:0] host;
        logic [FIELD_W-1:0]      load;
        logic [FIELD_W-1:0]      offered;
        logic [FIELD_W-1:0]      needed;
        logic [FIELD_W-1:0]      job;
        logic                    reason;
        logic                    pass;
        logic                    is_first;
        logic                    is_last;
        logic [FIELD_W-1:0]      rank;
    } job_item_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [FIELD_W-1:0]      cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [1:0]              opcode = '0;
    logic [USER_INDEX_W-1:0] user_index = '0;
    logic [HOST_INDEX_W-1:0] host_index = '0;
    logic [FIELD_W-1:0]      load_value = '0;
    logic [FIELD_W-1:0]      offered_slots = '0;
    logic [FIELD_W-1:0]      needed_slots = '0;
    logic [FIELD_W-1:0]      job_number = '0;
    logic                    has_pending_reason = 1'b0;
    logic                    reschedule_pass = 1'b0;
    logic                    first_host = 1'b0;
    logic                    last_host = 1'b0;
    logic [FIELD_W-1:0]      queue_rank = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [2:0]              outcome;
    logic [FIELD_W-1:0]      result_job;
    logic [HOST_INDEX_W-1:0] result_host;
    logic [FIELD_W-1:0]      result_rank;
    int                      fail_count;
    int                      pending;

    logic calm = 1'b0;
    int   items_sent = 0;

    capped_first_fit_job_dispatch dut (.*);
    cffd_checker checker_i (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 17);

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send(input job_item_t it);
        while (!calm && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        opcode             <= it.op;
        user_index         <= it.user;
        host_index         <= it.host;
        load_value         <= it.load;
        offered_slots      <= it.offered;
        needed_slots       <= it.needed;
        job_number         <= it.job;
        has_pending_reason <= it.reason;
        reschedule_pass    <= it.pass;
        first_host         <= it.is_first;
        last_host          <= it.is_last;
        queue_rank         <= it.rank;
        in_valid           <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // no item in flight and no decision outstanding
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [FIELD_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic set_limits(input logic [FIELD_W-1:0] per_round,
                              input logic [FIELD_W-1:0] per_user,
                              input logic [FIELD_W-1:0] per_host);
        write_reg(CFG_DISPATCH_LIMIT, per_round);
        write_reg(CFG_USER_JOB_LIMIT, per_user);
        write_reg(CFG_HOST_JOB_LIMIT, per_host);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_count(input opcode_t op, input logic [HOST_INDEX_W-1:0] idx,
                              input logic [FIELD_W-1:0] value);
        job_item_t it;
        it = '0;
        it.op   = op;
        it.user = idx[USER_INDEX_W-1:0];
        it.host = idx;
        it.load = value;
        send(it);
    endtask

    task automatic begin_round();
        job_item_t it;
        it = '0;
        it.op = OP_START_ROUND;
        send(it);
    endtask

    task automatic offer(input logic [FIELD_W-1:0] job, input logic [USER_INDEX_W-1:0] user,
                         input logic [HOST_INDEX_W-1:0] host,
                         input logic [FIELD_W-1:0] offered, input logic [FIELD_W-1:0] needed,
                         input logic reason, input logic pass, input logic is_first,
                         input logic is_last, input logic [FIELD_W-1:0] rank);
        job_item_t it;
        it = '0;
        it.op       = OP_CANDIDATE;
        it.job      = job;
        it.user     = user;
        it.host     = host;
        it.offered  = offered;
        it.needed   = needed;
        it.reason   = reason;
        it.pass     = pass;
        it.is_first = is_first;
        it.is_last  = is_last;
        it.rank     = rank;
        send(it);
    endtask

    // one job walking its host list; a broken one loses its first or last mark
    task automatic run_job(input bit broken);
        logic [FIELD_W-1:0]      job;
        logic [USER_INDEX_W-1:0] user;
        logic [FIELD_W-1:0]      needed;
        logic                    reason;
        logic                    pass;
        int                      hops;
        int                      drop;
        job    = FIELD_W'($urandom);
        user   = ($urandom_range(99) < 90) ? USER_INDEX_W'($urandom_range(0, 3))
                                           : USER_INDEX_W'($urandom_range(0, 63));
        needed = ($urandom_range(99) < 90) ? FIELD_W'($urandom_range(0, 4))
                                           : FIELD_W'($urandom);
        reason = 1'($urandom);
        pass   = ($urandom_range(99) < 85) ? reason : !reason;
        hops   = $urandom_range(1, 4);
        drop   = broken ? $urandom_range(0, 1) : 2;
        for (int k = 0; k < hops; k++)
        begin
            offer(job, user,
                  ($urandom_range(99) < 90) ? HOST_INDEX_W'($urandom_range(0, 7))
                                            : HOST_INDEX_W'($urandom_range(0, 255)),
                  ($urandom_range(99) < 90) ? FIELD_W'($urandom_range(0, 8))
                                            : FIELD_W'($urandom),
                  needed, reason, pass,
                  (k == 0) && (drop != 0), (k == hops - 1) && (drop != 1),
                  FIELD_W'($urandom));
        end
    endtask

    function automatic logic [FIELD_W-1:0] pick_limit();
        int roll;
        roll = $urandom_range(99);
        if (roll < 20)
            return '0;
        else if (roll < 30)
            return '1;
        else if (roll < 90)
            return FIELD_W'($urandom_range(1, 4));
        return FIELD_W'($urandom);
    endfunction

    initial
    begin
        job_item_t it;
        int        roll;
        int        phase_end;
        bit        drained;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no caps at all
        set_limits('0, '0, '0);
        load_count(OP_LOAD_USER, 8'd63, 16'hFFFF);
        load_count(OP_LOAD_USER, 8'd0, 16'h0000);
        load_count(OP_LOAD_HOST, 8'd255, 16'hFFFF);
        load_count(OP_LOAD_HOST, 8'd0, 16'h0000);
        begin_round();
        offer(16'hFFFF, 6'd63, 8'd255, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF);
        offer(16'h0000, 6'd0, 8'd0, 16'd9, 16'd1, 1'b1, 1'b0, 1'b1, 1'b1, 16'h1234);
        // first host too small, second fits, third is ignored
        offer(16'h0101, 6'd1, 8'd0, 16'd0, 16'd5, 1'b0, 1'b0, 1'b1, 1'b0, 16'd7);
        offer(16'h0101, 6'd1, 8'd1, 16'd10, 16'd5, 1'b0, 1'b0, 1'b0, 1'b0, 16'd8);
        offer(16'h0101, 6'd1, 8'd2, 16'd10, 16'd5, 1'b0, 1'b0, 1'b0, 1'b1, 16'd9);
        offer(16'h0202, 6'd2, 8'd3, 16'd1, 16'd2, 1'b0, 1'b0, 1'b1, 1'b0, 16'd1);
        offer(16'h0202, 6'd2, 8'd4, 16'd0, 16'd1, 1'b0, 1'b0, 1'b0, 1'b1, 16'd2);
        // host 255 already took one job, so an offer of zero is short by one
        offer(16'h0303, 6'd3, 8'd255, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 1'b1, 16'd3);
        settle();

        // user and host caps of one
        set_limits('1, 16'd1, 16'd1);
        begin_round();
        offer(16'h0404, 6'd5, 8'd9, 16'd4, 16'd1, 1'b0, 1'b0, 1'b1, 1'b1, 16'd4);
        offer(16'h0405, 6'd5, 8'd10, 16'd4, 16'd1, 1'b0, 1'b0, 1'b1, 1'b1, 16'd5);
        offer(16'h0406, 6'd6, 8'd9, 16'd4, 16'd1, 1'b0, 1'b0, 1'b1, 1'b1, 16'd6);
        offer(16'h0407, 6'd63, 8'd11, 16'd4, 16'd1, 1'b0, 1'b0, 1'b1, 1'b1, 16'd7);
        offer(16'h0408, 6'd7, 8'd255, 16'hFFFF, 16'd0, 1'b0, 1'b0, 1'b1, 1'b1, 16'd8);
        settle();

        // one job per round
        set_limits(16'd1, '0, '0);
        begin_round();
        offer(16'h0509, 6'd8, 8'd12, 16'd1, 16'd1, 1'b1, 1'b1, 1'b1, 1'b1, 16'd9);
        offer(16'h050A, 6'd8, 8'd12, 16'd9, 16'd1, 1'b1, 1'b1, 1'b1, 1'b1, 16'd10);

        for (int phase = 0; phase < 6; phase++)
        begin
            settle();
            case (phase)
                0: set_limits('0, '0, '0);
                1: set_limits('1, '1, '1);
                default: set_limits(pick_limit(), pick_limit(), pick_limit());
            endcase
            calm = (phase == 3);
            drained = 1'b0;
            begin_round();
            phase_end = items_sent + 220;
            while (items_sent < phase_end)
            begin
                roll = $urandom_range(99);
                if (roll < 4)
                    begin_round();
                else if (roll < 12)
                    load_count(($urandom_range(1) == 1) ? OP_LOAD_HOST : OP_LOAD_USER,
                               ($urandom_range(99) < 85) ? HOST_INDEX_W'($urandom_range(0, 7))
                                                         : HOST_INDEX_W'($urandom),
                               ($urandom_range(99) < 85) ? FIELD_W'($urandom_range(0, 3))
                                                         : FIELD_W'($urandom));
                else if (roll < 20)
                begin
                    it          = '0;
                    it.op       = opcode_t'($urandom_range(0, 3));
                    it.user     = USER_INDEX_W'($urandom);
                    it.host     = HOST_INDEX_W'($urandom);
                    it.load     = FIELD_W'($urandom);
                    it.offered  = FIELD_W'($urandom);
                    it.needed   = FIELD_W'($urandom);
                    it.job      = FIELD_W'($urandom);
                    it.reason   = 1'($urandom);
                    it.pass     = 1'($urandom);
                    it.is_first = 1'($urandom);
                    it.is_last  = 1'($urandom);
                    it.rank     = FIELD_W'($urandom);
                    send(it);
                end
                else
                    run_job(roll < 25);
                // hold the sender once until every decision is back
                if (phase == 2 && !drained && items_sent >= phase_end - 130)
                begin
                    settle();
                    drained = 1'b1;
                end
            end
        end

        settle();
        calm = 1'b0;
        repeat (6) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
